// ----- rtl/tssm_pkg.sv -----
// ----------------------------------------------------------------------------
// tssm_pkg
// Shared types and constants for the touch session slot map.
// ----------------------------------------------------------------------------
package tssm_pkg;

    localparam int SLOTS     = 16;
    localparam int ALIVE_MAX = 32;
    localparam int SW        = $clog2(SLOTS);
    localparam int AW        = $clog2(ALIVE_MAX);
    localparam int CW        = $clog2(ALIVE_MAX + 1);
    localparam int IDW       = 31;

    localparam logic [1:0] OP_ALIVE  = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] RK_ACCEPT = 2'd0;
    localparam logic [1:0] RK_DONE   = 2'd1;
    localparam logic [1:0] RK_HIT    = 2'd2;
    localparam logic [1:0] RK_MISS   = 2'd3;

    localparam logic [1:0] PROF_25DBLB = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SET_SCAN,
        ST_SET_RD,
        ST_SET_WR,
        ST_END_INIT,
        ST_KEEP_RD,
        ST_KEEP_SCAN,
        ST_FREE,
        ST_NEW_RD,
        ST_NEW_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [SW-1:0] slot;
        logic [15:0] prev_x;
        logic [15:0] prev_y;
        logic [15:0] next_x;
        logic [15:0] next_y;
        logic [15:0] next_z;
        logic [15:0] next_force;
        logic        ovf;
    } result_t;

endpackage

// ----- rtl/tssm_ram.sv -----
// ----------------------------------------------------------------------------
// tssm_ram
// Generic simple dual-port RAM (separate write and read addresses), one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/tssm_core.sv -----
// ----------------------------------------------------------------------------
// tssm_core
// Sequencer and id comparators walking slots and alive buffer.
// ----------------------------------------------------------------------------
module tssm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           op,
    input  logic [30:0]          id_in,
    input  logic [1:0]           profile,
    input  logic [15:0]          px,
    input  logic [15:0]          py,
    input  logic [15:0]          pz,
    input  logic [15:0]          pf,
    output logic                 busy,
    output logic                 done,
    output tssm_pkg::result_t    res,
    output logic [tssm_pkg::SLOTS-1:0] used
);
    import tssm_pkg::*;

    state_t state_reg, state_next;
    logic [SLOTS-1:0] used_reg, used_next, found_reg, found_next, cont_reg, cont_next;
    logic [IDW-1:0]   sess_reg [SLOTS];
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [SW:0]      j_reg, j_next;
    logic [IDW-1:0]   key_reg, key_next;
    logic [1:0]       prof_reg;
    logic [63:0]      pos_reg;
    result_t          res_reg, res_next;
    logic             held_reg, held_next;
    logic [SW-1:0]    free_reg, free_next;
    logic             hasfree_reg, hasfree_next;
    logic             sess_we;
    logic [SW-1:0]    sess_wa;

    logic             ab_we;
    logic [AW-1:0]    ab_ra;
    logic [IDW-1:0]   ab_rd;
    logic             nx_we;
    logic [63:0]      nx_wd, nx_rd;
    logic             pv_we;
    logic [31:0]      pv_wd, pv_rd;
    logic [SW-1:0]    hit_reg;
    logic [SW-1:0]    js;
    logic             match;

    assign js    = j_reg[SW-1:0];
    assign match = (sess_reg[js] == key_reg);

    tssm_ram #(.WIDTH(IDW), .DEPTH(ALIVE_MAX)) u_alive (
        .clk(clk), .we(ab_we), .waddr(cnt_reg[AW-1:0]), .wdata(id_in),
        .raddr(ab_ra), .rdata(ab_rd));
    tssm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_next (
        .clk(clk), .we(nx_we), .waddr(hit_reg), .wdata(nx_wd),
        .raddr(js), .rdata(nx_rd));
    tssm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_prev (
        .clk(clk), .we(pv_we), .waddr(hit_reg), .wdata(pv_wd),
        .raddr(js), .rdata(pv_rd));

    assign ab_we = start && (op == OP_ALIVE) && (cnt_reg < CW'(ALIVE_MAX));
    assign ab_ra = i_reg[AW-1:0];

    always_comb
    begin
        nx_wd = {(prof_reg == PROF_25DBLB) ? pos_reg[63:32] : nx_rd[63:32], pos_reg[31:0]};
        pv_wd = cont_reg[hit_reg] ? nx_rd[31:0] : pos_reg[31:0];
        nx_we = (state_reg == ST_SET_WR);
        pv_we = (state_reg == ST_SET_WR);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && op == OP_SET)
                    state_next = ST_SET_SCAN;
                else if (start && op == OP_END)
                    state_next = ST_END_INIT;
                else if (start && op == OP_ALIVE)
                    state_next = ST_OUT;
            end
            ST_SET_SCAN:
            begin
                if (used_reg[js] && match)
                    state_next = ST_SET_RD;
                else if (j_reg == (SW+1)'(SLOTS - 1))
                    state_next = ST_OUT;
            end
            ST_SET_RD:    state_next = ST_SET_WR;
            ST_SET_WR:    state_next = ST_OUT;
            ST_END_INIT:  state_next = (cnt_reg == '0) ? ST_FREE : ST_KEEP_RD;
            ST_KEEP_RD:   state_next = ST_KEEP_SCAN;
            ST_KEEP_SCAN:
            begin
                if ((used_reg[js] && !found_reg[js] && ab_rd == sess_reg[js])
                    || j_reg == (SW+1)'(SLOTS - 1))
                    state_next = (i_reg + 1'b1 == cnt_reg) ? ST_FREE : ST_KEEP_RD;
            end
            ST_FREE:      state_next = (cnt_reg == '0) ? ST_OUT : ST_NEW_RD;
            ST_NEW_RD:    state_next = ST_NEW_SCAN;
            ST_NEW_SCAN:
            begin
                if (j_reg == (SW+1)'(SLOTS - 1))
                    state_next = (i_reg + 1'b1 == cnt_reg) ? ST_OUT : ST_NEW_RD;
            end
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        used_next    = used_reg;
        found_next   = found_reg;
        cont_next    = cont_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        held_next    = held_reg;
        free_next    = free_reg;
        hasfree_next = hasfree_reg;
        sess_we      = 1'b0;
        sess_wa      = js;
        unique case (state_reg)
            ST_IDLE:
            begin
                j_next   = '0;
                i_next   = '0;
                key_next = id_in;
                res_next = '0;
                if (start && op == OP_ALIVE)
                begin
                    if (cnt_reg < CW'(ALIVE_MAX))
                        cnt_next = cnt_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    res_next.kind = RK_ACCEPT;
                    res_next.ovf  = ovf_next;
                end
                else if (start && op == OP_SET)
                begin
                    res_next.kind = RK_MISS;
                    res_next.ovf  = ovf_reg;
                end
                else if (start && op == OP_END)
                begin
                    res_next.kind = RK_DONE;
                    res_next.ovf  = ovf_reg;
                end
            end
            ST_SET_SCAN:
            begin
                if (!(used_reg[js] && match))
                    j_next = j_reg + 1'b1;
            end
            ST_SET_WR:
            begin
                res_next.kind       = RK_HIT;
                res_next.slot       = hit_reg;
                res_next.prev_x     = pv_wd[15:0];
                res_next.prev_y     = pv_wd[31:16];
                res_next.next_x     = nx_wd[15:0];
                res_next.next_y     = nx_wd[31:16];
                res_next.next_z     = nx_wd[47:32];
                res_next.next_force = nx_wd[63:48];
            end
            ST_END_INIT:
            begin
                cont_next  = used_reg;
                found_next = '0;
            end
            ST_KEEP_RD:
            begin
                j_next = '0;
            end
            ST_KEEP_SCAN:
            begin
                key_next = ab_rd;
                if (used_reg[js] && !found_reg[js] && ab_rd == sess_reg[js])
                begin
                    found_next[js] = 1'b1;
                    i_next = i_reg + 1'b1;
                end
                else if (j_reg == (SW+1)'(SLOTS - 1))
                    i_next = i_reg + 1'b1;
                else
                    j_next = j_reg + 1'b1;
            end
            ST_FREE:
            begin
                used_next  = used_reg & found_reg;
                found_next = '0;
                i_next     = '0;
            end
            ST_NEW_RD:
            begin
                j_next       = '0;
                held_next    = 1'b0;
                hasfree_next = 1'b0;
            end
            ST_NEW_SCAN:
            begin
                if (used_reg[js] && ab_rd == sess_reg[js])
                    held_next = 1'b1;
                if (!used_reg[js] && !hasfree_reg)
                begin
                    hasfree_next = 1'b1;
                    free_next    = js;
                end
                if (j_reg == (SW+1)'(SLOTS - 1))
                begin
                    i_next = i_reg + 1'b1;
                    if (!(held_reg || (used_reg[js] && ab_rd == sess_reg[js])))
                    begin
                        if (hasfree_reg || !used_reg[js])
                        begin
                            sess_we = 1'b1;
                            sess_wa = hasfree_reg ? free_reg : js;
                            used_next[sess_wa] = 1'b1;
                            cont_next[sess_wa] = 1'b0;
                        end
                    end
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (res_reg.kind == RK_DONE)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            found_reg <= '0;
            cont_reg  <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            found_reg <= found_next;
            cont_reg  <= cont_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
        held_reg    <= held_next;
        free_reg    <= free_next;
        hasfree_reg <= hasfree_next;
        if (state_reg == ST_IDLE)
        begin
            prof_reg <= profile;
            pos_reg  <= {pf, pz, py, px};
        end
        if (state_reg == ST_SET_SCAN)
            hit_reg <= js;
        if (sess_we)
            sess_reg[sess_wa] <= ab_rd;
    end

    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_OUT);
        res  = res_reg;
        used = used_reg;
    end
endmodule

// ----- rtl/touch_session_slot_map.sv -----
// ----------------------------------------------------------------------------
// touch_session_slot_map
// Maps touch session ids to 16 slots and tracks their positions.
//
// channel  dir  fields
// s_axis   in   tdata: operation, session_id, profile, pos_x, pos_y, pos_z, force_in
// m_axis   out  tdata: result_kind, slot_index, prev/next pos, occupied_mask, overflow
//
// Alive id: no slot walk. Set: walks the slots for a matching id.
// End: walks the slots twice per listed id, a keep pass and then a new-slot pass.
// Reset clears slot flags and alive count; no clearing pass.
// Input is taken again only after the result beat has left the output register.
// ----------------------------------------------------------------------------
module touch_session_slot_map (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation, session_id, profile, pos_x, pos_y, pos_z, force_in, zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_kind, slot_index, prev_x, prev_y, next_x, next_y, next_z,
    // next_force, occupied_mask, list_overflow, zero pad
    output logic [119:0] m_axis_tdata
);
    import tssm_pkg::*;

    logic             busy, done, start;
    result_t          res;
    logic [SLOTS-1:0] used;
    logic             ovalid_reg;
    logic [119:0]     odata_reg;
    logic [15:0]      occ;

    assign s_axis_tready = !busy && !ovalid_reg;
    assign start = s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] != OP_UNUSED);

    tssm_core u_core (
        .clk(clk), .rst_n(rst_n), .start(start),
        .op(s_axis_tdata[1:0]), .id_in(s_axis_tdata[32:2]),
        .profile(s_axis_tdata[34:33]), .px(s_axis_tdata[50:35]),
        .py(s_axis_tdata[66:51]), .pz(s_axis_tdata[82:67]),
        .pf(s_axis_tdata[98:83]), .busy(busy), .done(done),
        .res(res), .used(used));

    assign occ = 16'(used);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (done)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            odata_reg <= {1'b0, res.ovf, occ, res.next_force, res.next_z,
                          res.next_y, res.next_x, res.prev_y, res.prev_x,
                          4'(res.slot), res.kind};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule

// ----- rtl/tssm_checker.sv -----
// ----------------------------------------------------------------------------
// tssm_checker
// Port-level checks for the touch session slot map.
// ----------------------------------------------------------------------------
module tssm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [103:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata
);
    import tssm_pkg::*;

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_UNUSED |=> !s_axis_tready)
        else $error("second item taken during work");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == RK_MISS |-> m_axis_tdata[101:6] == '0)
        else $error("miss with nonzero position");
endmodule

bind touch_session_slot_map tssm_checker u_tssm_checker (.*);
